// ===== rtl/ersi_pkg.sv =====
// ----------------------------------------------------------------------------
// ersi_pkg
// Shared types and constants of the ema relative strength index block:
// fixed-point constants, register indexes and controller/datapath structs.
// ----------------------------------------------------------------------------
package ersi_pkg;

   localparam int FACTOR_WIDTH    = 17;
   localparam int RSI_WIDTH       = 15;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int MAC_CHUNK       = 24;
   localparam int Q16_BITS        = 16;
   localparam int SUM_LIMIT_BITS  = 48;
   localparam int DIV_CNT_WIDTH   = $clog2(RSI_WIDTH);

   // 25600 = 2^14 + 2^13 + 2^10
   localparam int RSI_SHIFT_HI  = 14;
   localparam int RSI_SHIFT_MID = 13;
   localparam int RSI_SHIFT_LO  = 10;

   localparam logic [FACTOR_WIDTH-1:0] ONE_Q16               = 17'h10000;
   localparam logic [FACTOR_WIDTH-1:0] ROUND_HALF            = 17'h08000;
   localparam logic [FACTOR_WIDTH-1:0] SMOOTHING_LONG_RESET  = 17'd6242;
   localparam logic [FACTOR_WIDTH-1:0] SMOOTHING_SHORT_RESET = 17'd9362;

   localparam logic [RSI_WIDTH-1:0] RSI_FULL = 15'd25600;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SMOOTHING_LONG  = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SMOOTHING_SHORT = 1'b1;

   typedef struct packed {
      logic accept;
      logic mac_init;
      logic mac_step;
      logic blend_write;
      logic channel;
      logic down_side;
      logic norm_load;
      logic norm_shift;
      logic div_load;
      logic div_step;
      logic div_capture;
      logic out_load;
   } ersi_cmd_type;

   typedef struct packed {
      logic restart;
      logic first_delta;
      logic mac_last;
      logic sum_big;
   } ersi_status_type;

   function automatic logic [FACTOR_WIDTH-1:0] sat_factor(
      input logic [FACTOR_WIDTH-1:0] value
   );
      return (value > ONE_Q16) ? ONE_Q16 : value;
   endfunction

endpackage

// ===== rtl/ersi_req_if.sv =====
// ----------------------------------------------------------------------------
// ersi_req_if
// Price channel: valid/ready handshake carrying one closing price per
// transaction.
// ----------------------------------------------------------------------------
interface ersi_req_if #(
   parameter int PRICE_WIDTH = 32
);
   logic                   valid;
   logic                   ready;
   logic [PRICE_WIDTH-1:0] close_price;
   logic                   series_start;

   modport source (
      output valid,
      output close_price,
      output series_start,
      input  ready
   );

   modport sink (
      input  valid,
      input  close_price,
      input  series_start,
      output ready
   );
endinterface

// ===== rtl/ersi_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ersi_rsp_if
// Result channel: valid/ready handshake carrying the long and short rsi
// values of one transaction.
// ----------------------------------------------------------------------------
interface ersi_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ersi_pkg::RSI_WIDTH-1:0] rsi_long;
   logic [ersi_pkg::RSI_WIDTH-1:0] rsi_short;

   modport source (
      output valid,
      output rsi_long,
      output rsi_short,
      input  ready
   );

   modport sink (
      input  valid,
      input  rsi_long,
      input  rsi_short,
      output ready
   );
endinterface

// ===== rtl/ema_relative_strength_index.sv =====
// ----------------------------------------------------------------------------
// ema_relative_strength_index
// Two-channel ema relative strength index over a stream of closing prices,
// built from a controller and a shared multiply/divide datapath.
//
//   channel   direction  transaction contents
//   req_bus   in         close_price, series_start
//   rsp_bus   out        rsi_long, rsi_short (q7.8)
//   csr_*     in         smoothing_long (index 0), smoothing_short (index 1)
//
// a delta runs the four blends, each summing 2*ceil(W/24) products of 24-bit
// chunks (W = price plus fraction bits), then normalizes and divides per channel
// the first delta of a series skips the blends
// a series start gives no result
// a delta runs the 15-step radix-2 divider once per channel and the 17x24
// multiplier shared by the four blends
// a result waits in the output register while the next price is taken; the
// next result stalls until the held one is taken
// ----------------------------------------------------------------------------
module ema_relative_strength_index #(
   parameter int PRICE_WIDTH   = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   ersi_req_if.sink                             req_bus,
   ersi_rsp_if.source                           rsp_bus,
   input  logic                                 csr_write_enable,
   input  logic [ersi_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ersi_pkg::FACTOR_WIDTH-1:0]    csr_write_data
);

   ersi_pkg::ersi_cmd_type    cmd;
   ersi_pkg::ersi_status_type status;

   ersi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ersi_dp #(
      .PRICE_WIDTH   (PRICE_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .close_price      (req_bus.close_price),
      .series_start     (req_bus.series_start),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsi_long         (rsp_bus.rsi_long),
      .rsi_short        (rsp_bus.rsi_short)
   );

`ifndef NO_ASSERTIONS
   a_rsi_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.rsi_long <= ersi_pkg::RSI_FULL &&
                         rsp_bus.rsi_short <= ersi_pkg::RSI_FULL))
      else $error("rsi result above full scale");

   a_restart_idle: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && status.restart) |=> req_bus.ready)
      else $error("series start left the block busy");

   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.mac_step, cmd.blend_write, cmd.norm_load, cmd.norm_shift,
                cmd.div_load, cmd.div_step, cmd.div_capture, cmd.out_load}))
      else $error("datapath commands overlap");

   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("result register overwritten while held");
`endif

endmodule

// ===== rtl/ersi_ctrl.sv =====
// ----------------------------------------------------------------------------
// ersi_ctrl
// Controller: sequences the four ema blends, the sum normalization and the
// shared divider for both channels, and owns the handshake valid/ready.
// ----------------------------------------------------------------------------
module ersi_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  ersi_pkg::ersi_status_type  status,
   output ersi_pkg::ersi_cmd_type     cmd
);

   typedef enum logic [7:0] {
      S_IDLE    = 8'b00000001,
      S_MAC     = 8'b00000010,
      S_WRITE   = 8'b00000100,
      S_LOAD    = 8'b00001000,
      S_NORM    = 8'b00010000,
      S_DIV     = 8'b00100000,
      S_CAPTURE = 8'b01000000,
      S_OUT_Q   = 8'b10000000
   } ersi_state_type;

   ersi_state_type                        state_ff, state_in;
   logic [1:0]                            blend_ff, blend_in;
   logic                                  chan_ff, chan_in;
   logic [ersi_pkg::DIV_CNT_WIDTH-1:0]    div_cnt_ff, div_cnt_in;
   logic                                  rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      blend_in   = blend_ff;
      chan_in    = chan_ff;
      div_cnt_in = div_cnt_ff;
      req_ready  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept   = 1'b1;
               cmd.mac_init = 1'b1;
               blend_in     = '0;
               chan_in      = 1'b0;
               if (status.restart) begin
                  state_in = S_IDLE;
               end else if (status.first_delta) begin
                  state_in = S_LOAD;
               end else begin
                  state_in = S_MAC;
               end
            end
         end
         S_MAC: begin
            cmd.channel   = blend_ff[1];
            cmd.down_side = blend_ff[0];
            cmd.mac_step  = 1'b1;
            if (status.mac_last) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.channel     = blend_ff[1];
            cmd.down_side   = blend_ff[0];
            cmd.blend_write = 1'b1;
            cmd.mac_init    = 1'b1;
            if (&blend_ff) begin
               state_in = S_LOAD;
            end else begin
               blend_in = blend_ff + 2'd1;
               state_in = S_MAC;
            end
         end
         S_LOAD: begin
            cmd.channel   = chan_ff;
            cmd.norm_load = 1'b1;
            state_in      = S_NORM;
         end
         S_NORM: begin
            cmd.channel = chan_ff;
            if (status.sum_big) begin
               cmd.norm_shift = 1'b1;
            end else begin
               cmd.div_load = 1'b1;
               div_cnt_in   = '0;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_cnt_ff == ersi_pkg::DIV_CNT_WIDTH'(ersi_pkg::RSI_WIDTH - 1)) begin
               state_in = S_CAPTURE;
            end
         end
         S_CAPTURE: begin
            cmd.channel     = chan_ff;
            cmd.div_capture = 1'b1;
            if (!chan_ff) begin
               chan_in  = 1'b1;
               state_in = S_LOAD;
            end else begin
               state_in = S_OUT_Q;
            end
         end
         S_OUT_Q: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         blend_ff     <= '0;
         chan_ff      <= 1'b0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         blend_ff     <= blend_in;
         chan_ff      <= chan_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/ersi_dp.sv =====
// ----------------------------------------------------------------------------
// ersi_dp
// Datapath: smoothing registers, price and ema state, chunked multiply-
// accumulate for the blends, sum normalization and radix-2 divider.
// ----------------------------------------------------------------------------
module ersi_dp #(
   parameter int PRICE_WIDTH   = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  ersi_pkg::ersi_cmd_type                  cmd,
   output ersi_pkg::ersi_status_type               status,
   input  logic [PRICE_WIDTH-1:0]                  close_price,
   input  logic                                    series_start,
   input  logic                                    csr_write_enable,
   input  logic [ersi_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [ersi_pkg::FACTOR_WIDTH-1:0]       csr_write_data,
   output logic [ersi_pkg::RSI_WIDTH-1:0]          rsi_long,
   output logic [ersi_pkg::RSI_WIDTH-1:0]          rsi_short
);

   localparam int EMA_W     = PRICE_WIDTH + FRACTION_BITS;
   localparam int SUM_W     = EMA_W + 1;
   localparam int ACC_W     = EMA_W + ersi_pkg::FACTOR_WIDTH;
   localparam int NCHUNK    = (EMA_W + ersi_pkg::MAC_CHUNK - 1) / ersi_pkg::MAC_CHUNK;
   localparam int PAD_W     = NCHUNK * ersi_pkg::MAC_CHUNK;
   localparam int PROD_W    = ersi_pkg::FACTOR_WIDTH + ersi_pkg::MAC_CHUNK;
   localparam int WIDE_W    = PAD_W + ersi_pkg::FACTOR_WIDTH;
   localparam int MAC_STEPS = 2 * NCHUNK;
   localparam int CNT_W     = $clog2(MAC_STEPS);
   localparam int NUM_W     = EMA_W + ersi_pkg::RSI_WIDTH;
   localparam int RW        = ersi_pkg::RSI_WIDTH;
   localparam int FW        = ersi_pkg::FACTOR_WIDTH;

   // configuration
   logic [FW-1:0] smoothing_long_ff;
   logic [FW-1:0] smoothing_short_ff;

   // series state
   logic                   have_prev_ff;
   logic                   first_ff;
   logic [PRICE_WIDTH-1:0] prev_ff;
   logic [EMA_W-1:0]       up_ff   [2];
   logic [EMA_W-1:0]       down_ff [2];
   logic [EMA_W-1:0]       x_ff;
   logic                   rise_ff;

   // multiply-accumulate
   logic [CNT_W-1:0] mac_cnt_ff;
   logic [ACC_W-1:0] acc_ff;

   // normalization and divider
   logic [EMA_W-1:0] up_w_ff, down_w_ff;
   logic [SUM_W-1:0] sum_ff, rem_ff;
   logic             zero_ff;
   logic [RW-1:0]    nlow_ff, q_ff;
   logic [RW-1:0]    hold_long_ff, hold_short_ff;
   logic [RW-1:0]    rsi_long_ff, rsi_short_ff;

   logic                   restart;
   logic                   rise;
   logic [PRICE_WIDTH-1:0] mag;
   logic [EMA_W-1:0]       x_new;
   logic [FW-1:0]          k_sel, rk_sel, fac;
   logic [EMA_W-1:0]       blend_in, ema_sel, operand;
   int                     shift_amt;
   logic [ersi_pkg::MAC_CHUNK-1:0] chunk;
   logic [PROD_W-1:0]      prod;
   logic [ACC_W-1:0]       term;
   logic [EMA_W-1:0]       blend_new;
   logic [SUM_W-1:0]       sum;
   logic [NUM_W-1:0]       numer;
   logic [SUM_W:0]         trial, diff;
   logic                   ge;
   logic [RW-1:0]          rsi_val;

   // price delta
   assign restart = series_start || !have_prev_ff;
   assign rise    = close_price > prev_ff;
   assign mag     = rise ? close_price - prev_ff : prev_ff - close_price;
   assign x_new   = {mag, {FRACTION_BITS{1'b0}}};

   // blend operand selection, one chunk per step
   assign k_sel     = cmd.channel ? ersi_pkg::sat_factor(smoothing_short_ff)
                                  : ersi_pkg::sat_factor(smoothing_long_ff);
   assign rk_sel    = ersi_pkg::ONE_Q16 - k_sel;
   assign blend_in  = (cmd.down_side != rise_ff) ? x_ff : '0;
   assign ema_sel   = cmd.down_side ? down_ff[cmd.channel] : up_ff[cmd.channel];
   assign operand   = mac_cnt_ff[0] ? ema_sel : blend_in;
   assign fac       = mac_cnt_ff[0] ? rk_sel : k_sel;
   assign shift_amt = ersi_pkg::MAC_CHUNK * int'(mac_cnt_ff >> 1);
   assign chunk     = ersi_pkg::MAC_CHUNK'(PAD_W'(operand) >> shift_amt);
   assign prod      = fac * chunk;
   assign term      = ACC_W'(WIDE_W'(prod) << shift_amt);
   assign blend_new = EMA_W'(acc_ff >> ersi_pkg::Q16_BITS);

   // normalization and divider
   assign sum   = SUM_W'(up_w_ff) + SUM_W'(down_w_ff);
   assign numer = (NUM_W'(up_w_ff) << ersi_pkg::RSI_SHIFT_HI)
                + (NUM_W'(up_w_ff) << ersi_pkg::RSI_SHIFT_MID)
                + (NUM_W'(up_w_ff) << ersi_pkg::RSI_SHIFT_LO);
   assign trial = {rem_ff, nlow_ff[RW-1]};
   assign ge    = trial >= {1'b0, sum_ff};
   assign diff  = trial - {1'b0, sum_ff};
   assign rsi_val = zero_ff ? ersi_pkg::RSI_FULL : q_ff;

   assign status.restart     = restart;
   assign status.first_delta = first_ff;
   assign status.mac_last    = (mac_cnt_ff == CNT_W'(MAC_STEPS - 1));
   assign status.sum_big     = (sum >> ersi_pkg::SUM_LIMIT_BITS) != '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         smoothing_long_ff  <= ersi_pkg::SMOOTHING_LONG_RESET;
         smoothing_short_ff <= ersi_pkg::SMOOTHING_SHORT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ersi_pkg::CSR_SMOOTHING_LONG:  smoothing_long_ff  <= csr_write_data;
            ersi_pkg::CSR_SMOOTHING_SHORT: smoothing_short_ff <= csr_write_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
         first_ff     <= 1'b1;
         mac_cnt_ff   <= '0;
      end else begin
         if (cmd.accept) begin
            have_prev_ff <= 1'b1;
            first_ff     <= restart;
         end
         if (cmd.mac_init) begin
            mac_cnt_ff <= '0;
         end else if (cmd.mac_step) begin
            mac_cnt_ff <= mac_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         prev_ff <= close_price;
         x_ff    <= x_new;
         rise_ff <= rise;
         if (restart) begin
            for (int c = 0; c < 2; c++) begin
               up_ff[c]   <= '0;
               down_ff[c] <= '0;
            end
         end else if (first_ff) begin
            for (int c = 0; c < 2; c++) begin
               if (rise) begin
                  up_ff[c] <= x_new;
               end else begin
                  down_ff[c] <= x_new;
               end
            end
         end
      end else if (cmd.blend_write) begin
         if (cmd.down_side) begin
            down_ff[cmd.channel] <= blend_new;
         end else begin
            up_ff[cmd.channel] <= blend_new;
         end
      end

      if (cmd.mac_init) begin
         acc_ff <= ACC_W'(ersi_pkg::ROUND_HALF);
      end else if (cmd.mac_step) begin
         acc_ff <= acc_ff + term;
      end

      if (cmd.norm_load) begin
         up_w_ff   <= up_ff[cmd.channel];
         down_w_ff <= down_ff[cmd.channel];
      end else if (cmd.norm_shift) begin
         up_w_ff   <= up_w_ff >> 1;
         down_w_ff <= down_w_ff >> 1;
      end

      if (cmd.div_load) begin
         sum_ff  <= sum;
         zero_ff <= (sum == '0);
         rem_ff  <= SUM_W'(numer >> RW);
         nlow_ff <= numer[RW-1:0];
         q_ff    <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= ge ? SUM_W'(diff) : SUM_W'(trial);
         q_ff    <= {q_ff[RW-2:0], ge};
         nlow_ff <= nlow_ff << 1;
      end

      if (cmd.div_capture) begin
         if (cmd.channel) begin
            hold_short_ff <= rsi_val;
         end else begin
            hold_long_ff <= rsi_val;
         end
      end

      if (cmd.out_load) begin
         rsi_long_ff  <= hold_long_ff;
         rsi_short_ff <= hold_short_ff;
      end
   end

   assign rsi_long  = rsi_long_ff;
   assign rsi_short = rsi_short_ff;

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ema_relative_strength_index. A short table of
// prices covers the extreme prices, series restarts, zero moves and a first
// price after reset that has no series start flag. Random runs of prices
// follow, starting from a series start and walking with small, medium or
// full-range steps, under several smoothing factors that include zero, one
// and values above one. An in-bench model of the two averages predicts each
// rsi pair not given in the table, and every result is checked in order.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRICE_WIDTH   = 32;
   localparam int FRACTION_BITS = 16;
   localparam int SETTLE_CYCLES = 150;
   localparam int PHASE_ITEMS   = 130;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;

   typedef struct packed {
      logic [ersi_pkg::RSI_WIDTH-1:0] rsi_long;
      logic [ersi_pkg::RSI_WIDTH-1:0] rsi_short;
   } rsi_pair_type;

   typedef struct packed {
      logic [PRICE_WIDTH-1:0] price;
      logic                   start;
      logic                   typed;
      rsi_pair_type           known;
   } price_row_type;

   localparam rsi_pair_type NO_RSI     = '0;
   localparam rsi_pair_type RSI_TOP    = '{ersi_pkg::RSI_FULL, ersi_pkg::RSI_FULL};
   localparam rsi_pair_type RSI_BOTTOM = '0;
   localparam int ROW_COUNT = 19;

   price_row_type price_rows [ROW_COUNT] = '{
      '{32'd500,        1'b0, 1'b0, NO_RSI},
      '{32'd500,        1'b0, 1'b1, RSI_TOP},
      '{32'hFFFF_FFFF,  1'b0, 1'b1, RSI_TOP},
      '{32'd0,          1'b0, 1'b0, NO_RSI},
      '{32'd0,          1'b0, 1'b0, NO_RSI},
      '{32'd77,         1'b0, 1'b0, NO_RSI},
      '{32'hFFFF_FFFF,  1'b1, 1'b0, NO_RSI},
      '{32'd0,          1'b0, 1'b1, RSI_BOTTOM},
      '{32'hFFFF_FFFF,  1'b0, 1'b0, NO_RSI},
      '{32'h8000_0000,  1'b1, 1'b0, NO_RSI},
      '{32'h8000_0001,  1'b0, 1'b1, RSI_TOP},
      '{32'h8000_0000,  1'b0, 1'b0, NO_RSI},
      '{32'h8000_0000,  1'b0, 1'b0, NO_RSI},
      '{32'h8000_0003,  1'b0, 1'b0, NO_RSI},
      '{32'h7FFF_FFFF,  1'b0, 1'b0, NO_RSI},
      '{32'd12345,      1'b1, 1'b0, NO_RSI},
      '{32'd12345,      1'b0, 1'b1, RSI_TOP},
      '{32'd12340,      1'b0, 1'b1, RSI_BOTTOM},
      '{32'd12350,      1'b0, 1'b0, NO_RSI}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                                 csr_write_enable;
   logic [ersi_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [ersi_pkg::FACTOR_WIDTH-1:0]    csr_write_data;

   ersi_req_if #(.PRICE_WIDTH(PRICE_WIDTH)) req_bus ();
   ersi_rsp_if rsp_bus ();

   ema_relative_strength_index #(
      .PRICE_WIDTH(PRICE_WIDTH),
      .FRACTION_BITS(FRACTION_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // model state
   logic [ersi_pkg::FACTOR_WIDTH-1:0] factor_reg [2];
   logic [PRICE_WIDTH-1:0]            last_price;
   bit                                have_last;
   bit                                seed_pending;
   bit [63:0]                         up_avg [2];
   bit [63:0]                         down_avg [2];

   rsi_pair_type pending_rsi [$];
   int           failure_count = 0;
   int unsigned  cycle_count = 0;
   bit           steady_flow = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic bit gap_now();
      return !steady_flow && ($urandom_range(0, 99) < 15);
   endfunction

   function automatic bit [63:0] ema_blend(input bit [63:0] x, input bit [63:0] e,
                                           input bit [63:0] k);
      bit [63:0] rk;
      bit [63:0] hi;
      bit [63:0] lo;
      rk = 64'd65536 - k;
      hi = (x >> 16) * k + (e >> 16) * rk;
      lo = (x & 64'hFFFF) * k + (e & 64'hFFFF) * rk;
      return hi + ((lo + 64'd32768) >> 16);
   endfunction

   function automatic logic [ersi_pkg::RSI_WIDTH-1:0] strength_of(input bit [63:0] up,
                                                                  input bit [63:0] down);
      bit [63:0] total;
      total = up + down;
      while ((total >> ersi_pkg::SUM_LIMIT_BITS) != 0) begin
         up = up >> 1;
         down = down >> 1;
         total = up + down;
      end
      if (total == 0)
         return ersi_pkg::RSI_FULL;
      return ersi_pkg::RSI_WIDTH'((64'(ersi_pkg::RSI_FULL) * up) / total);
   endfunction

   task automatic reset_averages();
      up_avg[0] = '0;
      up_avg[1] = '0;
      down_avg[0] = '0;
      down_avg[1] = '0;
   endtask

   task automatic advance_rsi(input logic [PRICE_WIDTH-1:0] price, input logic start,
                              output bit emits, output rsi_pair_type rsi);
      bit [63:0] move;
      bit [63:0] k;
      bit        rise;
      emits = 1'b0;
      rsi = NO_RSI;
      if (start || !have_last) begin
         last_price = price;
         have_last = 1'b1;
         seed_pending = 1'b1;
         reset_averages();
         return;
      end
      rise = price > last_price;
      move = rise ? 64'(price) - 64'(last_price) : 64'(last_price) - 64'(price);
      move = move << FRACTION_BITS;
      last_price = price;
      for (int c = 0; c < 2; c++) begin
         k = (factor_reg[c] > ersi_pkg::ONE_Q16) ? 64'(ersi_pkg::ONE_Q16)
                                                 : 64'(factor_reg[c]);
         if (seed_pending) begin
            if (rise)
               up_avg[c] = move;
            else
               down_avg[c] = move;
         end else if (rise) begin
            up_avg[c] = ema_blend(move, up_avg[c], k);
            down_avg[c] = ema_blend(64'd0, down_avg[c], k);
         end else begin
            up_avg[c] = ema_blend(64'd0, up_avg[c], k);
            down_avg[c] = ema_blend(move, down_avg[c], k);
         end
      end
      seed_pending = 1'b0;
      emits = 1'b1;
      rsi.rsi_long = strength_of(up_avg[0], down_avg[0]);
      rsi.rsi_short = strength_of(up_avg[1], down_avg[1]);
   endtask

   // entered and left at a falling edge, valid stays high after a transaction
   task automatic send_price(input logic [PRICE_WIDTH-1:0] price, input logic start,
                             input bit typed, input rsi_pair_type known);
      bit           emits;
      rsi_pair_type guess;
      while (gap_now()) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.close_price = price;
      req_bus.series_start = start;
      do
         @(posedge clock);
      while (!req_bus.ready);
      advance_rsi(price, start, emits, guess);
      if (typed)
         pending_rsi.push_back(known);
      else if (emits)
         pending_rsi.push_back(guess);
      @(negedge clock);
   endtask

   task automatic write_smoothing(input logic [ersi_pkg::CSR_INDEX_WIDTH-1:0] index,
                                  input logic [ersi_pkg::FACTOR_WIDTH-1:0] value);
      csr_write_enable = 1'b1;
      csr_index = index;
      csr_write_data = value;
      factor_reg[index] = value;
      @(negedge clock);
   endtask

   task automatic configure_phase(input logic [ersi_pkg::FACTOR_WIDTH-1:0] long_factor,
                                  input logic [ersi_pkg::FACTOR_WIDTH-1:0] short_factor);
      req_bus.valid = 1'b0;
      while (pending_rsi.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_smoothing(ersi_pkg::CSR_SMOOTHING_LONG, long_factor);
      write_smoothing(ersi_pkg::CSR_SMOOTHING_SHORT, short_factor);
      csr_write_enable = 1'b0;
   endtask

   task automatic run_random_prices(input int item_total);
      logic [PRICE_WIDTH-1:0] price;
      logic [PRICE_WIDTH-1:0] step;
      int                     run_left;
      run_left = 0;
      price = '0;
      for (int n = 0; n < item_total; n++) begin
         if (run_left == 0) begin
            run_left = $urandom_range(1, 24);
            price = ($urandom_range(0, 3) == 0) ? PRICE_WIDTH'($urandom_range(0, 255))
                                                : PRICE_WIDTH'($urandom);
            send_price(price, 1'b1, 1'b0, NO_RSI);
         end else begin
            case ($urandom_range(0, 9)) inside
               0: step = '0;
               [1:4]: step = PRICE_WIDTH'($urandom_range(0, 15));
               [5:7]: step = PRICE_WIDTH'($urandom_range(0, 65535));
               default: step = PRICE_WIDTH'($urandom);
            endcase
            if ($urandom_range(0, 1) == 1)
               price = price + step;
            else
               price = price - step;
            // stray restart inside a run
            send_price(price, $urandom_range(0, 39) == 0, 1'b0, NO_RSI);
            run_left--;
         end
      end
   endtask

   always @(negedge clock)
      rsp_bus.ready = !reset && !gap_now();

   always @(posedge clock) begin : check_rsi
      rsi_pair_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rsi.size() == 0) begin
            $error("rsi result with no transaction pending: rsi_long %0d, rsi_short %0d",
                   rsp_bus.rsi_long, rsp_bus.rsi_short);
            failure_count++;
         end else begin
            want = pending_rsi.pop_front();
            if (rsp_bus.rsi_long !== want.rsi_long) begin
               $error("rsi_long mismatch: expected %0d, actual %0d",
                      want.rsi_long, rsp_bus.rsi_long);
               failure_count++;
            end
            if (rsp_bus.rsi_short !== want.rsi_short) begin
               $error("rsi_short mismatch: expected %0d, actual %0d",
                      want.rsi_short, rsp_bus.rsi_short);
               failure_count++;
            end
         end
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.close_price = '0;
      req_bus.series_start = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = ersi_pkg::CSR_SMOOTHING_LONG;
      csr_write_data = '0;
      factor_reg[ersi_pkg::CSR_SMOOTHING_LONG] = ersi_pkg::SMOOTHING_LONG_RESET;
      factor_reg[ersi_pkg::CSR_SMOOTHING_SHORT] = ersi_pkg::SMOOTHING_SHORT_RESET;
      last_price = '0;
      have_last = 1'b0;
      seed_pending = 1'b1;
      reset_averages();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (price_rows[r])
         send_price(price_rows[r].price, price_rows[r].start, price_rows[r].typed,
                    price_rows[r].known);

      configure_phase('0, ersi_pkg::ONE_Q16);
      run_random_prices(PHASE_ITEMS);
      configure_phase(ersi_pkg::ONE_Q16, '1);
      run_random_prices(PHASE_ITEMS);
      configure_phase(17'd1, ersi_pkg::FACTOR_WIDTH'($urandom_range(0, 65536)));
      run_random_prices(PHASE_ITEMS);
      configure_phase(ersi_pkg::FACTOR_WIDTH'($urandom_range(0, 65536)),
                      ersi_pkg::FACTOR_WIDTH'($urandom_range(0, 65536)));
      steady_flow = 1'b1;
      run_random_prices(PHASE_ITEMS);
      steady_flow = 1'b0;
      configure_phase(ersi_pkg::FACTOR_WIDTH'($urandom), ersi_pkg::FACTOR_WIDTH'($urandom));
      run_random_prices(PHASE_ITEMS);

      req_bus.valid = 1'b0;
      while (pending_rsi.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failure_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
